// ===== rtl/bgfr_pkg.sv =====
// Package: shared constants, command codes and widths for the bit-granular frame reader.
`timescale 1ns / 1ps

package bgfr_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int IDX_W       = $clog2(STORE_BYTES);
    localparam int BANK_DEPTH  = STORE_BYTES / 2;
    localparam int BANK_AW     = IDX_W - 1;
    localparam int PHYS_W      = IDX_W + 3;

    localparam int CMD_W      = 3;
    localparam int LADDR_W    = 12;
    localparam int BYTE_W     = 8;
    localparam int AMOUNT_W   = 17;
    localparam int COUNT_W    = 4;
    localparam int LEN_W      = 16;
    localparam int OFF_W      = 3;
    localparam int WHOLE_W    = 13;
    localparam int TARGET_W   = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD      = 3'd0,
        CMD_SEEK_ABS  = 3'd1,
        CMD_SEEK_ENCL = 3'd2,
        CMD_MOVE      = 3'd3,
        CMD_READ      = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_LEN   = 2'd0,
        REG_FIRST_OFF   = 2'd1,
        REG_START_OFF   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

endpackage

// ===== rtl/bgfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bgfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bit_granular_frame_reader_unit.sv =====
// Top level: MSB-first bit reader over a banked byte store with a bit cursor.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  command, load_address, load_byte, bit_amount,
//                                                bit_count
//  m_axis    out  m_axis_tvalid / m_axis_tready  read_data, status, remaining_bits,
//                                                whole_bytes_left
//  cfg       in   cfg_wr_en                      cfg_index, cfg_wr_data
//
//  Load, seek, move and refused commands: the result is registered straight from the transaction.
//  Accepted read: the even and odd store banks deliver both bytes of the window
//  in the cycle after the transaction, and the input waits until the byte is registered.
//  The output register frees the input side as soon as its result is taken.
//  Reset clears the cursor, state, output valid and config registers; the store holds no reset value.
`timescale 1ns / 1ps

module bit_granular_frame_reader_unit
    import bgfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] command, [14:3] load_address, [22:15] load_byte,
    // [39:23] bit_amount, [43:40] bit_count, [47:44] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] read_data, [8] status, [24:9] remaining_bits,
    // [37:25] whole_bytes_left, [39:38] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    logic [LEN_W-1:0]  frame_length_bits_reg;
    logic [OFF_W-1:0]  first_byte_bit_offset_reg;
    logic [LEN_W-1:0]  frame_start_offset_reg;
    logic [LEN_W-1:0]  cursor_reg, cursor_next;
    state_t            state_reg, state_next;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  read_data_reg, read_data_next;
    logic               status_reg, status_next;
    logic [LEN_W-1:0]   remaining_reg, remaining_next;

    logic               odd_first_reg;
    logic [OFF_W-1:0]   shift_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [CMD_W-1:0]    command;
    logic [LADDR_W-1:0]  load_address;
    logic [BYTE_W-1:0]   load_byte;
    logic [AMOUNT_W-1:0] bit_amount;
    logic [COUNT_W-1:0]  bit_count;

    logic               in_accept;
    logic               place_ok;
    logic               read_ok;
    logic               step_ok;
    logic [TARGET_W-1:0] target;
    logic [LEN_W-1:0]   bits_left;
    logic [PHYS_W-1:0]  phys;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   load_idx;

    logic [BANK_AW-1:0] even_raddr, odd_raddr;
    logic [BYTE_W-1:0]  even_rdata, odd_rdata;
    logic               even_we, odd_we;
    logic [15:0]        window;

    assign command      = s_axis_tdata[2:0];
    assign load_address = s_axis_tdata[14:3];
    assign load_byte    = s_axis_tdata[22:15];
    assign bit_amount   = s_axis_tdata[39:23];
    assign bit_count    = s_axis_tdata[43:40];

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign bits_left = (frame_length_bits_reg > cursor_reg)
                     ? (frame_length_bits_reg - cursor_reg) : '0;

    assign phys = PHYS_W'(first_byte_bit_offset_reg) + PHYS_W'(cursor_reg);
    assign idx  = phys[3 +: IDX_W];
    assign odd_raddr  = idx[IDX_W-1:1];
    assign even_raddr = idx[IDX_W-1:1] + BANK_AW'(idx[0]);

    assign load_idx = IDX_W'(load_address);
    assign even_we  = in_accept && (command == CMD_LOAD) && !load_idx[0];
    assign odd_we   = in_accept && (command == CMD_LOAD) && load_idx[0];

    bgfr_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_even_bank (
        .clk   (clk),
        .we    (even_we),
        .waddr (load_idx[IDX_W-1:1]),
        .wdata (load_byte),
        .raddr (even_raddr),
        .rdata (even_rdata)
    );

    bgfr_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_odd_bank (
        .clk   (clk),
        .we    (odd_we),
        .waddr (load_idx[IDX_W-1:1]),
        .wdata (load_byte),
        .raddr (odd_raddr),
        .rdata (odd_rdata)
    );

    always_comb
    begin
        target = '0;
        unique case (command)
            CMD_SEEK_ABS:
            begin
                target = TARGET_W'($signed(bit_amount));
            end
            CMD_SEEK_ENCL:
            begin
                target = TARGET_W'($signed(bit_amount)) - TARGET_W'(frame_start_offset_reg);
            end
            CMD_MOVE:
            begin
                target = TARGET_W'(cursor_reg) + TARGET_W'($signed(bit_amount));
            end
            default:
            begin
                target = '0;
            end
        endcase
    end

    assign place_ok = !target[TARGET_W-1]
                   && (target <= TARGET_W'(frame_length_bits_reg));
    assign read_ok  = (bit_count != '0) && (bit_count <= COUNT_W'(8))
                   && (bits_left >= LEN_W'(bit_count));

    always_comb
    begin
        step_ok     = 1'b0;
        cursor_next = cursor_reg;
        state_next  = state_reg;
        if (in_accept)
        begin
            case (command)
                CMD_LOAD:
                begin
                    step_ok = 1'b1;
                end
                CMD_SEEK_ABS, CMD_SEEK_ENCL, CMD_MOVE:
                begin
                    step_ok = place_ok;
                    if (place_ok)
                    begin
                        cursor_next = target[LEN_W-1:0];
                    end
                end
                CMD_READ:
                begin
                    step_ok = read_ok;
                    if (read_ok)
                    begin
                        cursor_next = cursor_reg + LEN_W'(bit_count);
                        state_next  = ST_READ;
                    end
                end
                default:
                begin
                    step_ok = 1'b0;
                end
            endcase
        end
        else if (state_reg == ST_READ)
        begin
            state_next = ST_IDLE;
        end
    end

    assign window = (odd_first_reg ? {odd_rdata, even_rdata} : {even_rdata, odd_rdata})
                  << shift_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        status_next    = status_reg;
        remaining_next = remaining_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_accept)
        begin
            read_data_next = '0;
            status_next    = !step_ok;
            remaining_next = (frame_length_bits_reg > cursor_next)
                           ? (frame_length_bits_reg - cursor_next) : '0;
            out_valid_next = !(step_ok && (command == CMD_READ));
        end
        else if (state_reg == ST_READ)
        begin
            read_data_next = window[15:8] >> (COUNT_W'(8) - count_reg);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                 <= ST_IDLE;
            cursor_reg                <= '0;
            out_valid_reg             <= 1'b0;
            frame_length_bits_reg     <= '0;
            first_byte_bit_offset_reg <= '0;
            frame_start_offset_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_FRAME_LEN: frame_length_bits_reg     <= cfg_wr_data[LEN_W-1:0];
                    REG_FIRST_OFF: first_byte_bit_offset_reg <= cfg_wr_data[OFF_W-1:0];
                    REG_START_OFF: frame_start_offset_reg    <= cfg_wr_data[LEN_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        status_reg    <= status_next;
        remaining_reg <= remaining_next;
        if (in_accept)
        begin
            odd_first_reg <= idx[0];
            shift_reg     <= phys[OFF_W-1:0];
            count_reg     <= bit_count;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, remaining_reg[LEN_W-1:3], remaining_reg,
                            status_reg, read_data_reg};

`ifndef NO_ASSERTIONS
    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> !s_axis_tready)
        else $error("input accepted during read window fetch");

    a_read_enters_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (command == CMD_READ) && read_ok) |=> (state_reg == ST_READ))
        else $error("accepted read did not enter fetch state");

    a_fetch_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> m_axis_tvalid)
        else $error("read fetch produced no result");

    a_refused_keeps_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !step_ok) |=> $stable(cursor_reg))
        else $error("refused transaction moved the cursor");

    a_result_flags_refusal: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !step_ok) |=> (m_axis_tvalid && status_reg))
        else $error("refused transaction not reported");
`endif

endmodule
